>>> sv/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the cubic B-spline curve evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

    // control point store geometry
    localparam int MAX_POINTS = 64;
    localparam int PT_IDX_W   = $clog2(MAX_POINTS);
    localparam int NUM_BANKS  = 4;
    localparam int BANK_W     = $clog2(NUM_BANKS);
    localparam int BANK_DEPTH = MAX_POINTS / NUM_BANKS;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    // datapath widths
    localparam int COORD_W    = 32;
    localparam int NUM_COORDS = 3;
    localparam int NUM_TERMS  = 4;
    localparam int PARAM_W    = 17;
    localparam int SEG_W      = 6;
    localparam int CAGE_W     = 36;
    localparam int WGT_W      = 29;
    localparam int SPLIT      = 18;
    localparam int LO_W       = SPLIT + WGT_W;
    localparam int HI_W       = (CAGE_W - SPLIT) + WGT_W + 1;
    localparam int LO_SUM_W   = LO_W + 2;
    localparam int HI_SUM_W   = HI_W + 2;
    localparam int ACC_W      = 68;

    localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [NUM_COORDS-1:0]   t_point;
    // four consecutive points: seg-1, seg, seg+1, seg+2
    typedef t_point [NUM_TERMS-1:0]    t_window;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } t_req;

endpackage

`default_nettype wire

>>> sv/bsp_store.sv
// ----------------------------------------------------------------------------
// bsp_store
// Control point store in four banks, one per index modulo four, so that four
// consecutive points are read together. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_store (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [bsp_pkg::PT_IDX_W-1:0] i_wr_idx,
    input  wire bsp_pkg::t_point          i_wr_pt,
    input  wire logic                     i_rd_en,
    input  wire logic [bsp_pkg::PT_IDX_W-1:0] i_rd_base,
    output bsp_pkg::t_window              o_win
);
    import bsp_pkg::*;

    t_point               r_mem [NUM_BANKS][BANK_DEPTH];
    t_point               r_rd  [NUM_BANKS];
    logic [BANK_W-1:0]    r_base_lo;
    logic [BANK_AW-1:0]   rd_addr [NUM_BANKS];

    // per bank address of the one window point that lives there
    always_comb begin
        logic [BANK_W-1:0]   j;
        logic [PT_IDX_W-1:0] idx;
        for (int b = 0; b < NUM_BANKS; b++) begin
            j          = BANK_W'(b) - i_rd_base[BANK_W-1:0];
            idx        = i_rd_base + PT_IDX_W'(j);
            rd_addr[b] = idx[PT_IDX_W-1:BANK_W];
        end
    end

    // bank write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_idx[BANK_W-1:0]][i_wr_idx[PT_IDX_W-1:BANK_W]] <= i_wr_pt;
        end
        if (i_rd_en) begin
            for (int b = 0; b < NUM_BANKS; b++) begin
                r_rd[b] <= r_mem[b][rd_addr[b]];
            end
            r_base_lo <= i_rd_base[BANK_W-1:0];
        end
    end

    // put bank outputs back in window order
    always_comb begin
        logic [BANK_W-1:0] bsel;
        for (int j = 0; j < NUM_TERMS; j++) begin
            bsel     = r_base_lo + BANK_W'(j);
            o_win[j] = r_rd[bsel];
        end
    end

endmodule

`default_nettype wire

>>> sv/cubic_bspline_curve_evaluator_top.sv
// ----------------------------------------------------------------------------
// cubic_bspline_curve_evaluator_top
// Uniform cubic B-spline evaluator over a 64-entry store of 3D points.
// ----------------------------------------------------------------------------
// busy is always low: one request is taken every cycle. A load request writes
// its point at the transfer edge and produces nothing. An evaluate request
// raises o_valid once it has passed the store read, the weight multipliers and
// the split 36x29 products with their adder tree. The receiver cannot stall,
// so a result is presented for exactly one cycle. A load may be followed at
// once by an evaluate that uses the new point.
`default_nettype none

module cubic_bspline_curve_evaluator_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_cfg_we,
    input  wire logic [5:0]                  i_cfg_wdata,
    input  wire logic                        i_req_type,
    input  wire logic [bsp_pkg::PT_IDX_W-1:0] i_point_index,
    input  wire logic signed [31:0]          i_point_x,
    input  wire logic signed [31:0]          i_point_y,
    input  wire logic signed [31:0]          i_point_z,
    input  wire logic [bsp_pkg::PARAM_W-1:0] i_param,
    output logic                             o_valid,
    output logic signed [31:0]               o_curve_x,
    output logic signed [31:0]               o_curve_y,
    output logic signed [31:0]               o_curve_z,
    output logic [bsp_pkg::SEG_W-1:0]        o_segment
);
    import bsp_pkg::*;

    logic [SEG_W-1:0] r_nseg;

    // request decode
    logic accept, ld_go, ev_go;
    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign ld_go  = accept & (t_req'(i_req_type) == REQ_LOAD);
    assign ev_go  = accept & (t_req'(i_req_type) == REQ_EVAL);

    // segment count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nseg <= SEG_W'(1);
        end else if (i_cfg_we) begin
            r_nseg <= i_cfg_wdata;
        end
    end

    // segment select and local parameter
    logic [SEG_W-1:0]         n_eff, nm1, seg, rd_base;
    logic [PARAM_W-1:0]       p_sat;
    logic [PARAM_W+SEG_W-1:0] pn, t_full;
    logic [SEG_W:0]           seg_raw;

    always_comb begin
        n_eff   = (r_nseg == '0) ? SEG_W'(1) : r_nseg;
        nm1     = n_eff - SEG_W'(1);
        p_sat   = (i_param > ONE_Q16) ? ONE_Q16 : i_param;
        pn      = (PARAM_W+SEG_W)'(p_sat) * (PARAM_W+SEG_W)'(n_eff);
        seg_raw = pn[PARAM_W+SEG_W-1:16];
        seg     = (seg_raw > {1'b0, nm1}) ? nm1 : seg_raw[SEG_W-1:0];
        t_full  = pn - {1'b0, seg, 16'b0};
        rd_base = seg - SEG_W'(1);
    end

    t_point  wr_pt;
    t_window win;
    assign wr_pt[0] = i_point_x;
    assign wr_pt[1] = i_point_y;
    assign wr_pt[2] = i_point_z;

    bsp_store u_store (
        .i_clk     (i_clk),
        .i_we      (ld_go),
        .i_wr_idx  (i_point_index),
        .i_wr_pt   (wr_pt),
        .i_rd_en   (ev_go),
        .i_rd_base (rd_base),
        .o_win     (win)
    );

    // stage a registers
    logic                r_a_vld, r_a_first, r_a_last;
    logic [SEG_W-1:0]    r_a_seg;
    logic [PARAM_W-1:0]  r_a_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= ev_go;
        end
        r_a_seg   <= seg;
        r_a_t     <= t_full[PARAM_W-1:0];
        r_a_first <= (seg == '0);
        r_a_last  <= (seg == nm1);
    end

    // stage b: bezier cage and squares
    logic signed [CAGE_W-1:0] q [NUM_COORDS][NUM_TERMS];
    logic [PARAM_W-1:0]       u_b;

    always_comb begin
        logic signed [CAGE_W-1:0] cm, cs, c1, c2, mid;
        for (int k = 0; k < NUM_COORDS; k++) begin
            cm  = CAGE_W'(win[0][k]);
            cs  = CAGE_W'(win[1][k]);
            c1  = CAGE_W'(win[2][k]);
            c2  = r_a_last ? c1 : CAGE_W'(win[3][k]);
            mid = (cs + c1) <<< 1;
            q[k][0] = r_a_first ? (cs <<< 3) : (((cs <<< 1) + cm + c1) <<< 1);
            q[k][3] = r_a_last  ? (c1 <<< 3) : (((c1 <<< 1) + cs + c2) <<< 1);
            q[k][1] = mid + (q[k][0] >>> 1);
            q[k][2] = mid + (q[k][3] >>> 1);
        end
        u_b = ONE_Q16 - r_a_t;
    end

    logic                     r_b_vld;
    logic [SEG_W-1:0]         r_b_seg;
    logic signed [CAGE_W-1:0] r_b_q [NUM_COORDS][NUM_TERMS];
    logic [PARAM_W-1:0]       r_b_u, r_b_t;
    logic [2*PARAM_W-1:0]     r_b_u2, r_b_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_seg <= r_a_seg;
        r_b_q   <= q;
        r_b_u   <= u_b;
        r_b_t   <= r_a_t;
        r_b_u2  <= (2*PARAM_W)'(u_b) * (2*PARAM_W)'(u_b);
        r_b_t2  <= (2*PARAM_W)'(r_a_t) * (2*PARAM_W)'(r_a_t);
    end

    // stage c: bernstein weights in q1.28
    localparam int M_W = 3 * PARAM_W;
    logic [M_W-1:0]   m0, m1, m2, m3;
    logic [M_W+1:0]   m1x3, m2x3;
    logic [WGT_W-1:0] w [NUM_TERMS];

    always_comb begin
        m0   = M_W'(r_b_u2) * M_W'(r_b_u);
        m1   = M_W'(r_b_u2) * M_W'(r_b_t);
        m2   = M_W'(r_b_t2) * M_W'(r_b_u);
        m3   = M_W'(r_b_t2) * M_W'(r_b_t);
        m1x3 = ((M_W+2)'(m1) << 1) + (M_W+2)'(m1);
        m2x3 = ((M_W+2)'(m2) << 1) + (M_W+2)'(m2);
        w[0] = m0[WGT_W+19:20];
        w[1] = m1x3[WGT_W+19:20];
        w[2] = m2x3[WGT_W+19:20];
        w[3] = m3[WGT_W+19:20];
    end

    logic                     r_c_vld;
    logic [SEG_W-1:0]         r_c_seg;
    logic signed [CAGE_W-1:0] r_c_q [NUM_COORDS][NUM_TERMS];
    logic [WGT_W-1:0]         r_c_w [NUM_TERMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_seg <= r_b_seg;
        r_c_q   <= r_b_q;
        r_c_w   <= w;
    end

    // stage d: split partial products
    logic                   r_d_vld;
    logic [SEG_W-1:0]       r_d_seg;
    logic [LO_W-1:0]        r_d_lo [NUM_COORDS][NUM_TERMS];
    logic signed [HI_W-1:0] r_d_hi [NUM_COORDS][NUM_TERMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_seg <= r_c_seg;
        for (int k = 0; k < NUM_COORDS; k++) begin
            for (int i = 0; i < NUM_TERMS; i++) begin
                r_d_lo[k][i] <= LO_W'(r_c_q[k][i][SPLIT-1:0]) * LO_W'(r_c_w[i]);
                r_d_hi[k][i] <= HI_W'($signed(r_c_q[k][i][CAGE_W-1:SPLIT]))
                              * HI_W'($signed({1'b0, r_c_w[i]}));
            end
        end
    end

    // stage e: term sums
    logic                       r_e_vld;
    logic [SEG_W-1:0]           r_e_seg;
    logic [LO_SUM_W-1:0]        r_e_lo [NUM_COORDS];
    logic signed [HI_SUM_W-1:0] r_e_hi [NUM_COORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_seg <= r_d_seg;
        for (int k = 0; k < NUM_COORDS; k++) begin
            r_e_lo[k] <= LO_SUM_W'(r_d_lo[k][0]) + LO_SUM_W'(r_d_lo[k][1])
                       + LO_SUM_W'(r_d_lo[k][2]) + LO_SUM_W'(r_d_lo[k][3]);
            r_e_hi[k] <= HI_SUM_W'(r_d_hi[k][0]) + HI_SUM_W'(r_d_hi[k][1])
                       + HI_SUM_W'(r_d_hi[k][2]) + HI_SUM_W'(r_d_hi[k][3]);
        end
    end

    // stage f: combine, floor shift and saturate
    t_coord res [NUM_COORDS];

    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic [ACC_W-32:0]       qv;
        for (int k = 0; k < NUM_COORDS; k++) begin
            acc = (ACC_W'(r_e_hi[k]) <<< SPLIT) + $signed(ACC_W'(r_e_lo[k]));
            qv  = acc[ACC_W-1:31];
            if (qv[ACC_W-32:31] == '0 || qv[ACC_W-32:31] == '1) begin
                res[k] = qv[31:0];
            end else if (qv[ACC_W-32]) begin
                res[k] = {1'b1, 31'b0};
            end else begin
                res[k] = {1'b0, {31{1'b1}}};
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_e_vld;
        end
        o_curve_x <= res[0];
        o_curve_y <= res[1];
        o_curve_z <= res[2];
        o_segment <= r_e_seg;
    end

endmodule

`default_nettype wire

>>> verif/cubic_bspline_curve_evaluator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_curve_evaluator_checker
// Watches the request, config and result ports of the curve evaluator. Keeps
// its own copy of the control point table and segment count, works out the
// curve point of every evaluate transfer and compares each result strobe
// with the oldest expected point, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bspline_curve_evaluator_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic                         i_busy,
    input  wire logic                         i_cfg_we,
    input  wire logic [5:0]                   i_cfg_wdata,
    input  wire logic                         i_req_type,
    input  wire logic [bsp_pkg::PT_IDX_W-1:0] i_point_index,
    input  wire logic signed [31:0]           i_point_x,
    input  wire logic signed [31:0]           i_point_y,
    input  wire logic signed [31:0]           i_point_z,
    input  wire logic [bsp_pkg::PARAM_W-1:0]  i_param,
    input  wire logic                         i_valid,
    input  wire logic signed [31:0]           i_curve_x,
    input  wire logic signed [31:0]           i_curve_y,
    input  wire logic signed [31:0]           i_curve_z,
    input  wire logic [bsp_pkg::SEG_W-1:0]    i_segment,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_points_checked
);
    import bsp_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [SEG_W-1:0]   seg;
    } t_curve_pt;

    t_point    ctrl_pts [MAX_POINTS];
    logic [5:0] seg_count;
    t_curve_pt curve_q [$];

    // saturate a floored Q16.16 sum to 32 bits
    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // expected curve point for one parameter under the current table
    function automatic t_curve_pt curve_at(input logic [PARAM_W-1:0] prm);
        t_curve_pt r;
        longint n, p, s, t, u, w0, w1, w2, w3;
        longint cm, cs, c1, c2, q0, q1, q2, q3, mid, acc;
        logic signed [31:0] res [3];
        n = seg_count;
        if (n == 0) n = 1;
        if (n > MAX_POINTS - 1) n = MAX_POINTS - 1;
        p = prm;
        if (p > 65536) p = 65536;
        s = (p * n) >> 16;
        if (s > n - 1) s = n - 1;
        t = p * n - (s << 16);
        if (t > 65536) t = 65536;
        u = 65536 - t;
        w0 = (u * u * u) >> 20;
        w1 = (3 * u * u * t) >> 20;
        w2 = (3 * u * t * t) >> 20;
        w3 = (t * t * t) >> 20;
        for (int k = 0; k < 3; k++) begin
            cs = ctrl_pts[s][k];
            c1 = ctrl_pts[s+1][k];
            cm = (s == 0) ? cs : longint'(ctrl_pts[s-1][k]);
            c2 = (s >= n - 1) ? longint'(ctrl_pts[n][k]) : longint'(ctrl_pts[s+2][k]);
            // bezier cage of the segment, scaled by 8, pinned at curve ends
            q0 = (s == 0) ? 8 * cs : 2 * (2 * cs + cm + c1);
            q3 = (s >= n - 1) ? 8 * c2 : 2 * (2 * c1 + cs + c2);
            mid = 2 * (cs + c1);
            q1 = mid + q0 / 2;
            q2 = mid + q3 / 2;
            acc = q0 * w0 + q1 * w1 + q2 * w2 + q3 * w3;
            res[k] = clip32(acc >>> 31);
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        r.seg = s[SEG_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_curve_pt want;
        if (!i_rst_n) begin
            foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
            seg_count = 6'd1;
            curve_q.delete();
            o_fail_count = 0;
            o_points_checked = 0;
        end else begin
            if (i_cfg_we) seg_count = i_cfg_wdata;
            // request transfer: load updates the table, evaluate queues a point
            if (i_start && !i_busy) begin
                if (t_req'(i_req_type) == REQ_LOAD) begin
                    ctrl_pts[i_point_index][0] = i_point_x;
                    ctrl_pts[i_point_index][1] = i_point_y;
                    ctrl_pts[i_point_index][2] = i_point_z;
                end else begin
                    curve_q.push_back(curve_at(i_param));
                end
            end
            // result transfer
            if (i_valid) begin
                if (curve_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result x=%0d y=%0d z=%0d seg=%0d",
                                 i_curve_x, i_curve_y, i_curve_z, i_segment);
                end else begin
                    want = curve_q.pop_front();
                    o_points_checked++;
                    if (want.x !== i_curve_x || want.y !== i_curve_y ||
                        want.z !== i_curve_z || want.seg !== i_segment) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("curve point differs: exp %0d %0d %0d seg %0d, got %0d %0d %0d seg %0d",
                                     want.x, want.y, want.z, want.seg,
                                     i_curve_x, i_curve_y, i_curve_z, i_segment);
                    end
                end
            end
        end
        o_pending = curve_q.size();
    end

endmodule

`default_nettype wire

>>> verif/cubic_bspline_curve_evaluator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bspline_curve_evaluator_top_tb
// Drives load and evaluate requests into the curve evaluator in random bursts
// over several segment counts, and lets the checker predict and compare.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bspline_curve_evaluator_top_tb;
    import bsp_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [5:0]            i_cfg_wdata;
    logic                  i_req_type;
    logic [PT_IDX_W-1:0]   i_point_index;
    logic signed [31:0]    i_point_x, i_point_y, i_point_z;
    logic [PARAM_W-1:0]    i_param;
    logic                  o_valid;
    logic signed [31:0]    o_curve_x, o_curve_y, o_curve_z;
    logic [SEG_W-1:0]      o_segment;

    int fail_count, pending, points_checked;
    int idle_cycles;
    int burst_left;
    int n_loads, n_evals, n_phases;
    logic [5:0] cur_segs;

    cubic_bspline_curve_evaluator_top i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_wdata,
        .i_req_type, .i_point_index, .i_point_x, .i_point_y, .i_point_z,
        .i_param, .o_valid, .o_curve_x, .o_curve_y, .o_curve_z, .o_segment
    );

    cubic_bspline_curve_evaluator_checker i_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_wdata,
        .i_req_type, .i_point_index, .i_point_x, .i_point_y, .i_point_z,
        .i_param, .i_valid(o_valid), .i_curve_x(o_curve_x), .i_curve_y(o_curve_y),
        .i_curve_z(o_curve_z), .i_segment(o_segment),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_points_checked(points_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("cubic_bspline_curve_evaluator_top: mismatch");
                $finish;
            end
        end
    end

    // one request, held until the transfer, then maybe a random gap
    task automatic issue(input t_req kind, input logic [PT_IDX_W-1:0] idx,
                         input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] z, input logic [PARAM_W-1:0] prm);
        start         <= 1'b1;
        i_req_type    <= kind;
        i_point_index <= idx;
        i_point_x     <= x;
        i_point_y     <= y;
        i_point_z     <= z;
        i_param       <= prm;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == REQ_LOAD) n_loads++; else n_evals++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // stop requests and wait until every curve point is back
    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        @(negedge i_clk);
        while (pending != 0 && guard < 1000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_segments(input logic [5:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_segs = v;
        n_phases++;
    endtask

    function automatic logic [31:0] coord_val();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
            default: return $urandom;
        endcase
    endfunction

    // parameters near segment boundaries, at the ends, above one, or anywhere
    function automatic logic [PARAM_W-1:0] param_val();
        int n, b;
        n = (cur_segs == 0) ? 1 : cur_segs;
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return PARAM_W'($urandom_range(65537, 131071));
            3, 4: begin
                b = ($urandom_range(0, n) * 65536) / n + $urandom_range(0, 2) - 1;
                if (b < 0) b = 0;
                return b[PARAM_W-1:0];
            end
            5: return PARAM_W'($urandom);
            default: return PARAM_W'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        logic [5:0] seg_plan [8];
        start = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        i_req_type = 1'b0; i_point_index = '0;
        i_point_x = '0; i_point_y = '0; i_point_z = '0; i_param = '0;
        burst_left = 0; n_loads = 0; n_evals = 0; n_phases = 0;
        cur_segs = 6'd1;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table so every read hits a written point
        for (int i = 0; i < MAX_POINTS; i++)
            issue(REQ_LOAD, PT_IDX_W'(i), coord_val(), coord_val(), coord_val(),
                  PARAM_W'($urandom));

        // directed: extreme points, parameter ends and above one, reset count
        issue(REQ_LOAD, 0, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, '0);
        issue(REQ_LOAD, 1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, '0);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd0);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd65536);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd131071);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd32768);
        issue(REQ_LOAD, 1, 32'h80000000, 32'h7FFFFFFF, 32'h00010000, '0);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd65535);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd1);
        set_segments(6'd0);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd40000);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd65536);
        set_segments(6'd63);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd0);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd65536);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd1041);
        issue(REQ_EVAL, 0, 0, 0, 0, 17'd65535);

        // random phases over several segment counts
        seg_plan = '{6'd1, 6'd63, 6'd2, 6'd0, 6'd5, 6'd17, 6'd3, 6'd40};
        for (int ph = 0; ph < 8; ph++) begin
            set_segments((ph == 7) ? 6'($urandom_range(1, 63)) : seg_plan[ph]);
            for (int k = 0; k < 160; k++) begin
                if ($urandom_range(0, 9) < 3)
                    issue(REQ_LOAD, PT_IDX_W'($urandom), coord_val(), coord_val(),
                          coord_val(), PARAM_W'($urandom));
                else
                    issue(REQ_EVAL, PT_IDX_W'($urandom), $urandom, $urandom,
                          $urandom, param_val());
            end
        end
        drain();

        $display("ran %0d loads and %0d evaluates over %0d segment settings",
                 n_loads, n_evals, n_phases);
        $display("%0d curve points compared", points_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("cubic_bspline_curve_evaluator_top: match");
        end else begin
            $display("cubic_bspline_curve_evaluator_top: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
